### rtl/pel_pkg.sv
`timescale 1ns / 1ps

package pel_pkg;

    // Field and storage widths fixed by the block definition
    localparam int CFG_WIDTH     = 11;
    localparam int POS_WIDTH     = 10;
    localparam int ENERGY_WIDTH  = 16;
    localparam int CELL_WIDTH    = 40;
    localparam int ROOT_ONE_BITS = 16;

    localparam logic [CFG_WIDTH-1:0]  CFG_RESET = 11'd1024;
    localparam logic [CELL_WIDTH-1:0] CELL_MAX  = 40'hFF_FFFF_FFFF;

    // energy * 1000 needs 26 bits
    localparam int              SCALED_BASE_W = 26;
    localparam logic [9:0]      ENERGY_SCALE  = 10'd1000;

    // table build: isqrt(2^34 / d), 35-bit operand, 18-bit root
    localparam int ROOT_IN_W = 35;
    localparam int ROOT_Q_W  = 18;

    // divide by three: reciprocal ceil(2^25 / 3), exact below 2^25
    localparam logic [23:0] DIV3_MULT  = 24'hAA_AAAB;
    localparam int          DIV3_SHIFT = 25;
    localparam int          HALF_W     = 21;
    localparam int          SUM3_W     = CELL_WIDTH + 2;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic div_init;
        logic div_part;
        logic sqrt_start;
        logic init_write;
        logic sweep_part;
        logic sweep_relax;
        logic out_load;
    } pel_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic sweep_done;
        logic init_last;
        logic out_busy;
    } pel_status_t;

endpackage

### rtl/pel_item_if.sv
`timescale 1ns / 1ps

interface pel_item_if;
    logic                               valid;
    logic                               ready;
    logic                               kind;
    logic [pel_pkg::POS_WIDTH-1:0]      impact_position;
    logic [pel_pkg::ENERGY_WIDTH-1:0]   impact_energy;

    modport source (output valid, kind, impact_position, impact_energy, input ready);
    modport sink   (input valid, kind, impact_position, impact_energy, output ready);
endinterface

### rtl/pel_result_if.sv
`timescale 1ns / 1ps

interface pel_result_if;
    logic                               valid;
    logic                               ready;
    logic [pel_pkg::CELL_WIDTH-1:0]     peak_value;
    logic [pel_pkg::POS_WIDTH-1:0]      peak_position;
    logic                               peak_found;

    modport source (output valid, peak_value, peak_position, peak_found, input ready);
    modport sink   (input valid, peak_value, peak_position, peak_found, output ready);
endinterface

### rtl/pel_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module pel_div #(
    parameter int DIVIDEND_W = 42,
    parameter int DIVISOR_W  = 11
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNTW = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg, dsr_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic                  busy_reg, done_reg;
    logic [DIVISOR_W:0]    shifted;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // shift and subtract
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? DIVISOR_W'(shifted - {1'b0, dsr_reg}) : shifted[DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/pel_isqrt.sv
`timescale 1ns / 1ps

// Integer square root, two operand bits per cycle
module pel_isqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pel_pkg::ROOT_IN_W-1:0]   value,
    output logic                            done,
    output logic [pel_pkg::ROOT_Q_W-1:0]    root
);

    localparam int W = pel_pkg::ROOT_IN_W + 1;

    logic [W-1:0] v_reg, r_reg, b_reg;
    logic [W-1:0] trial;
    logic         busy_reg, done_reg;

    assign trial = r_reg + b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && b_reg == W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // one result bit per step, bit walks down the even positions
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= W'(value);
            r_reg <= '0;
            b_reg <= W'(1) << (pel_pkg::ROOT_IN_W - 1);
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
                r_reg <= r_reg >> 1;
            b_reg <= b_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[pel_pkg::ROOT_Q_W-1:0];

endmodule

### rtl/pel_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: table build after reset, then one item at a time
module pel_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_kind,
    output logic                  in_ready,
    input  pel_pkg::pel_status_t  status,
    output pel_pkg::pel_cmd_t     cmd
);

    localparam logic [3:0] S_INIT_START = 4'd0;
    localparam logic [3:0] S_INIT_DIV   = 4'd1;
    localparam logic [3:0] S_INIT_SQRT  = 4'd2;
    localparam logic [3:0] S_INIT_WRITE = 4'd3;
    localparam logic [3:0] S_IDLE       = 4'd4;
    localparam logic [3:0] S_PART_START = 4'd5;
    localparam logic [3:0] S_PART_DIV   = 4'd6;
    localparam logic [3:0] S_PART_SWEEP = 4'd7;
    localparam logic [3:0] S_RELAX      = 4'd8;
    localparam logic [3:0] S_RESULT     = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_INIT_START;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_INIT_START:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_INIT_DIV;
            end
            S_INIT_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = S_INIT_SQRT;
                end
            end
            S_INIT_SQRT:
            begin
                if (status.sqrt_done)
                    state_next = S_INIT_WRITE;
            end
            S_INIT_WRITE:
            begin
                cmd.init_write = 1'b1;
                state_next     = status.init_last ? S_IDLE : S_INIT_START;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (in_kind)
                    begin
                        cmd.sweep_relax = 1'b1;
                        state_next      = S_RELAX;
                    end
                    else
                        state_next = S_PART_START;
                end
            end
            S_PART_START:
            begin
                cmd.div_part = 1'b1;
                state_next   = S_PART_DIV;
            end
            S_PART_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.sweep_part = 1'b1;
                    state_next     = S_PART_SWEEP;
                end
            end
            S_PART_SWEEP:
            begin
                if (status.sweep_done)
                    state_next = S_IDLE;
            end
            S_RELAX:
            begin
                if (status.sweep_done)
                    state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_INIT_START;
        endcase
    end

    a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.div_init, cmd.div_part, cmd.sqrt_start, cmd.init_write,
                  cmd.sweep_part, cmd.sweep_relax, cmd.out_load}))
        else $error("more than one datapath command at once");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !status.out_busy)
        else $error("result loaded over a pending one");
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken straight after the first");

endmodule

### rtl/pel_dpath.sv
`timescale 1ns / 1ps

// Cell memory, inverse-root table, particle and relaxation pipelines
module pel_dpath #(
    parameter int MAX_CELLS      = 1024,
    parameter int CELL_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pel_pkg::pel_cmd_t                   cmd,
    output pel_pkg::pel_status_t                status,
    input  logic [pel_pkg::CFG_WIDTH-1:0]       cfg_cells,
    input  logic [pel_pkg::POS_WIDTH-1:0]       in_position,
    input  logic [pel_pkg::ENERGY_WIDTH-1:0]    in_energy,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [pel_pkg::CELL_WIDTH-1:0]      out_value,
    output logic [pel_pkg::POS_WIDTH-1:0]       out_position,
    output logic                                out_found
);

    localparam int CWD  = pel_pkg::CELL_WIDTH;
    localparam int NW   = $clog2(MAX_CELLS + 1);
    localparam int IW   = $clog2(MAX_CELLS);
    localparam int SW   = pel_pkg::SCALED_BASE_W + CELL_FRAC_BITS;
    localparam int DDW  = (SW > pel_pkg::ROOT_IN_W) ? SW : pel_pkg::ROOT_IN_W;
    localparam int RB   = pel_pkg::ROOT_ONE_BITS;
    localparam int PW   = SW - RB;
    localparam int AW   = SW + 1;
    localparam int EW   = ((AW > CWD) ? AW : CWD) + 1;
    localparam int DSW  = ((pel_pkg::POS_WIDTH > NW) ? pel_pkg::POS_WIDTH : NW) + 1;
    localparam int CW   = (pel_pkg::CFG_WIDTH > NW) ? pel_pkg::CFG_WIDTH : NW;
    localparam int HW   = pel_pkg::HALF_W;
    localparam int S3W  = pel_pkg::SUM3_W;
    localparam int QW   = pel_pkg::ROOT_Q_W;

    // storage
    logic [CWD-1:0] layer_mem [0:MAX_CELLS-1];
    logic [RB-1:0]  rom_mem   [0:MAX_CELLS];

    // item latch
    logic [NW-1:0]                    n_reg;
    logic [pel_pkg::POS_WIDTH-1:0]    pos_reg;
    logic [pel_pkg::ENERGY_WIDTH-1:0] energy_reg;
    logic [CW-1:0]                    cfg_e;
    logic [NW-1:0]                    n_clamp;

    always_comb
    begin
        cfg_e = CW'(cfg_cells);
        priority if (cfg_e == '0)
            n_clamp = NW'(1);
        else if (cfg_e > CW'(MAX_CELLS))
            n_clamp = NW'(MAX_CELLS);
        else
            n_clamp = cfg_e[NW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            n_reg      <= n_clamp;
            pos_reg    <= in_position;
            energy_reg <= in_energy;
        end
    end

    // shared divider: table build and particle scaling
    logic [NW-1:0]                     entry_reg;
    logic [pel_pkg::SCALED_BASE_W-1:0] e_scaled;
    logic [DDW-1:0]                    div_dividend, div_quo;
    logic [NW-1:0]                     div_divisor;
    logic                              div_done;

    assign e_scaled     = pel_pkg::SCALED_BASE_W'(energy_reg)
                        * pel_pkg::SCALED_BASE_W'(pel_pkg::ENERGY_SCALE);
    assign div_dividend = cmd.div_init ? (DDW'(1) << (pel_pkg::ROOT_IN_W - 1))
                                       : DDW'({e_scaled, {CELL_FRAC_BITS{1'b0}}});
    assign div_divisor  = cmd.div_init ? entry_reg : n_reg;

    pel_div #(.DIVIDEND_W(DDW), .DIVISOR_W(NW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_init | cmd.div_part),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    logic          sqrt_done;
    logic [QW-1:0] root;

    pel_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sqrt_start),
        .value (div_quo[pel_pkg::ROOT_IN_W-1:0]),
        .done  (sqrt_done),
        .root  (root)
    );

    // table entry: rounded half of the root, saturated, zero at entry zero
    logic [QW:0]   root_p1;
    logic [RB-1:0] rom_val;

    always_comb
    begin
        root_p1 = {1'b0, root} + 1'b1;
        priority if (entry_reg == '0)
            rom_val = '0;
        else if (root_p1[QW:1] > QW'({RB{1'b1}}))
            rom_val = {RB{1'b1}};
        else
            rom_val = root_p1[RB:1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else if (cmd.init_write && entry_reg != NW'(MAX_CELLS))
            entry_reg <= entry_reg + 1'b1;
    end

    // sweep address generator
    logic          sweep_act_reg, relax_reg;
    logic [NW-1:0] a_reg;
    logic          last_iss, rd_en, rom_en;
    logic [IW-1:0] rd_addr;
    logic [NW-1:0] rom_addr;
    logic [DSW-1:0] pos_e, a_e, dist_abs, idx_e;

    assign last_iss = relax_reg ? (a_reg == n_reg) : (a_reg == n_reg - 1'b1);
    assign rd_en    = sweep_act_reg && (a_reg < n_reg);
    assign rd_addr  = a_reg[IW-1:0];
    assign rom_en   = sweep_act_reg && !relax_reg;

    always_comb
    begin
        pos_e    = DSW'(pos_reg);
        a_e      = DSW'(a_reg);
        dist_abs = (pos_e > a_e) ? (pos_e - a_e) : (a_e - pos_e);
        idx_e    = dist_abs + 1'b1;
        rom_addr = (idx_e > DSW'(MAX_CELLS)) ? NW'(MAX_CELLS) : idx_e[NW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_act_reg <= 1'b0;
            relax_reg     <= 1'b0;
            a_reg         <= '0;
        end
        else if (cmd.sweep_part || cmd.sweep_relax)
        begin
            sweep_act_reg <= 1'b1;
            relax_reg     <= cmd.sweep_relax;
            a_reg         <= '0;
        end
        else if (sweep_act_reg)
        begin
            a_reg <= a_reg + 1'b1;
            if (last_iss)
                sweep_act_reg <= 1'b0;
        end
    end

    // stage 1: memory reads
    logic           s1_v_reg, s1_zero_reg;
    logic [NW-1:0]  s1_a_reg;
    logic [CWD-1:0] mem_q_reg;
    logic [RB-1:0]  rom_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else
            s1_v_reg <= sweep_act_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_a_reg    <= a_reg;
        s1_zero_reg <= !(a_reg < n_reg);
    end

    // cell memory write port selection
    logic           wr_en;
    logic [IW-1:0]  wr_addr;
    logic [CWD-1:0] wr_data;
    logic           s2_v_reg, r2_v_reg;
    logic [NW-1:0]  s2_a_reg, r2_i_reg;
    logic [CWD-1:0] part_wdata, relax_new;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        priority if (cmd.init_write && entry_reg != NW'(MAX_CELLS))
        begin
            wr_en   = 1'b1;
            wr_addr = entry_reg[IW-1:0];
        end
        else if (s2_v_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = s2_a_reg[IW-1:0];
            wr_data = part_wdata;
        end
        else if (r2_v_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = r2_i_reg[IW-1:0];
            wr_data = relax_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            layer_mem[wr_addr] <= wr_data;
        if (rd_en)
            mem_q_reg <= layer_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_write)
            rom_mem[entry_reg] <= rom_val;
        if (rom_en)
            rom_q_reg <= rom_mem[rom_addr];
    end

    // particle stage 2: attenuation products
    logic [SW-1:0]  p_hi_reg;
    logic [RB-1:0]  p_lo_reg;
    logic [CWD-1:0] p_cell_reg;
    logic [SW-1:0]  scaled;
    logic [SW-1:0]  hi_prod;
    logic [2*RB-1:0] lo_prod;

    assign scaled  = div_quo[SW-1:0];
    assign hi_prod = SW'(scaled[SW-1:RB]) * SW'(rom_q_reg);
    assign lo_prod = scaled[RB-1:0] * rom_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else
            s2_v_reg <= s1_v_reg && !relax_reg;
    end

    always_ff @(posedge clk)
    begin
        p_hi_reg   <= hi_prod;
        p_lo_reg   <= lo_prod[2*RB-1:RB];
        p_cell_reg <= mem_q_reg;
        s2_a_reg   <= s1_a_reg;
    end

    // saturating accumulate
    logic [AW-1:0] p_add;
    logic [EW-1:0] p_sum;

    always_comb
    begin
        p_add      = AW'(p_hi_reg) + AW'(p_lo_reg);
        p_sum      = EW'(p_add) + EW'(p_cell_reg);
        part_wdata = (p_sum > EW'(pel_pkg::CELL_MAX)) ? pel_pkg::CELL_MAX : p_sum[CWD-1:0];
    end

    // relaxation window: three-cell sum centred one behind the read
    logic [CWD-1:0] w1_reg, w2_reg, cur;
    logic           r1_v_reg;
    logic [NW-1:0]  r1_i_reg;
    logic [S3W-1:0] r1_sum_reg;

    assign cur = s1_zero_reg ? '0 : mem_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r1_v_reg <= 1'b0;
        else
            r1_v_reg <= s1_v_reg && relax_reg && (s1_a_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sweep_relax)
        begin
            w1_reg <= '0;
            w2_reg <= '0;
        end
        else if (s1_v_reg && relax_reg)
        begin
            w2_reg <= w1_reg;
            w1_reg <= cur;
        end
        r1_sum_reg <= S3W'(w2_reg) + S3W'(w1_reg) + S3W'(cur);
        r1_i_reg   <= s1_a_reg - 1'b1;
    end

    // divide by three, high half first
    logic [HW-1:0]  hi3;
    logic [HW+23:0] hi3_prod;
    logic [19:0]    qh;
    logic [HW-1:0]  rh;
    logic [19:0]    r2_qh_reg;
    logic [HW+1:0]  r2_mid_reg;

    always_comb
    begin
        hi3      = r1_sum_reg[S3W-1:HW];
        hi3_prod = (HW+24)'(hi3) * (HW+24)'(pel_pkg::DIV3_MULT);
        qh       = hi3_prod[HW+23:pel_pkg::DIV3_SHIFT];
        rh       = hi3 - (HW'(qh) + HW'({qh, 1'b0}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r2_v_reg <= 1'b0;
        else
            r2_v_reg <= r1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        r2_qh_reg  <= qh;
        r2_mid_reg <= {rh[1:0], r1_sum_reg[HW-1:0]};
        r2_i_reg   <= r1_i_reg;
    end

    // low half and recombine
    logic [HW+25:0] lo3_prod;
    logic [HW:0]    ql;
    logic [CWD:0]   relax_full;

    always_comb
    begin
        lo3_prod   = (HW+26)'(r2_mid_reg) * (HW+26)'(pel_pkg::DIV3_MULT);
        ql         = lo3_prod[HW+pel_pkg::DIV3_SHIFT:pel_pkg::DIV3_SHIFT];
        relax_full = ((CWD+1)'(r2_qh_reg) << HW) + (CWD+1)'(ql);
        relax_new  = relax_full[CWD-1:0];
    end

    // peak scan over interior cells
    logic [CWD-1:0] best_reg;
    logic [NW-1:0]  best_pos_reg;
    logic           found_reg;
    logic           interior;

    assign interior = (r2_i_reg != '0) && (({1'b0, r2_i_reg} + 1'b1) < {1'b0, n_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg     <= '0;
            best_pos_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (cmd.sweep_relax)
        begin
            best_reg     <= '0;
            best_pos_reg <= '0;
            found_reg    <= 1'b0;
        end
        else if (r2_v_reg && interior && relax_new > best_reg)
        begin
            best_reg     <= relax_new;
            best_pos_reg <= r2_i_reg;
            found_reg    <= 1'b1;
        end
    end

    // result register
    logic                          out_valid_reg;
    logic [CWD-1:0]                out_value_reg;
    logic [pel_pkg::POS_WIDTH-1:0] out_pos_reg;
    logic                          out_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg <= best_reg;
            out_pos_reg   <= pel_pkg::POS_WIDTH'(best_pos_reg);
            out_found_reg <= found_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign out_position = out_pos_reg;
    assign out_found    = out_found_reg;

    assign status.div_done   = div_done;
    assign status.sqrt_done  = sqrt_done;
    assign status.sweep_done = !sweep_act_reg && !s1_v_reg && !s2_v_reg
                             && !r1_v_reg && !r2_v_reg;
    assign status.init_last  = entry_reg == NW'(MAX_CELLS);
    assign status.out_busy   = out_valid_reg;

    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("cell read and write collide");
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_found_reg) |-> (out_value_reg == '0 && out_pos_reg == '0))
        else $error("empty result carries a value");
    a_sweep_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep_part || cmd.sweep_relax) |-> status.sweep_done)
        else $error("sweep started over a running one");

endmodule

### rtl/particle_energy_layer_step.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                         Transaction
// items     in   kind, impact_position, impact_energy            valid & ready
// results   out  peak_value, peak_position, peak_found           valid & ready
// cfg       in   cfg_write_data (cells_in_use)                   cfg_write_en
//
// Particle: scaling in the shared divider, then a sweep over the n cells, one cell per
//   cycle through the single cell memory's separate read and write ports.
// End of storm: a relaxation sweep, one cell per cycle, then the result register loads.
// After reset the table build runs over MAX_CELLS+1 entries, each through the divider
//   then the root unit; items are held off meanwhile.
// A pending result does not hold off particle items; the next storm end waits for it.
module particle_energy_layer_step #(
    parameter int MAX_CELLS      = 1024,
    parameter int CELL_FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [pel_pkg::CFG_WIDTH-1:0]   cfg_write_data,
    pel_item_if.sink                        items,
    pel_result_if.source                    results
);

    logic [pel_pkg::CFG_WIDTH-1:0] cells_in_use_reg;
    pel_pkg::pel_cmd_t             cmd;
    pel_pkg::pel_status_t          status;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cells_in_use_reg <= pel_pkg::CFG_RESET;
        else if (cfg_write_en)
            cells_in_use_reg <= cfg_write_data;
    end

    pel_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .in_kind  (items.kind),
        .in_ready (items.ready),
        .status   (status),
        .cmd      (cmd)
    );

    pel_dpath #(
        .MAX_CELLS      (MAX_CELLS),
        .CELL_FRAC_BITS (CELL_FRAC_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_cells    (cells_in_use_reg),
        .in_position  (items.impact_position),
        .in_energy    (items.impact_energy),
        .out_valid    (results.valid),
        .out_ready    (results.ready),
        .out_value    (results.peak_value),
        .out_position (results.peak_position),
        .out_found    (results.peak_found)
    );

endmodule
